// ===== rtl/hsrb_pkg.sv =====
// Shared types, constants and saturation helpers of the heat stencil row builder.
package hsrb_pkg;

   localparam int IDX_W          = 10;
   localparam int DATA_W         = 32;
   localparam int COEF_W         = 48;
   localparam int QUEUE_DEPTH    = 4;
   localparam int DEF_NODE_DEPTH = 1024;
   localparam int CSR_IDX_W      = 1;

   localparam logic [DATA_W-1:0] TIME_STEP_RESET = 32'd655;
   localparam logic [DATA_W-1:0] HOT_VALUE_RESET = 32'd6553600;

   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOT_VALUE = 1'd1;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_BUILD = 1'b1;

   localparam logic [1:0] LOAD_HOT  = 2'd0;
   localparam logic [1:0] LOAD_ZERO = 2'd1;
   localparam logic [1:0] LOAD_PREV = 2'd2;

   localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic signed [COEF_W-1:0] COEF_ONE = 48'sd65536;

   // One neighbor reference: absent flag and the index already wrapped to the table.
   typedef struct packed {
      logic             absent;
      logic [IDX_W-1:0] idx;
   } link_type;

   // One queued item as handed from the front to the back.
   typedef struct packed {
      logic              build;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  slot;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] k;
      link_type [3:0]    link;
   } entry_type;

   function automatic logic signed [COEF_W:0] ext49(input logic signed [COEF_W-1:0] v);
      return {v[COEF_W-1], v};
   endfunction

   function automatic logic signed [COEF_W-1:0] sat48(input logic signed [COEF_W:0] v);
      if (v[COEF_W] != v[COEF_W-1]) begin
         return v[COEF_W] ? COEF_MIN : COEF_MAX;
      end
      return v[COEF_W-1:0];
   endfunction

endpackage

// ===== rtl/hsrb_front.sv =====
// Front end: accepts items, wraps node indices, flags absent neighbors and queues items.
module hsrb_front #(
   parameter int NODE_DEPTH = hsrb_pkg::DEF_NODE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_type,
   input  logic [9:0]               req_node_index,
   input  logic signed [31:0]       req_pos_x,
   input  logic signed [31:0]       req_pos_y,
   input  logic [31:0]              req_conductivity,
   input  logic signed [10:0]       req_east_neighbor,
   input  logic signed [10:0]       req_north_neighbor,
   input  logic signed [10:0]       req_west_neighbor,
   input  logic signed [10:0]       req_south_neighbor,
   input  logic                     pop,
   output logic                     q_valid,
   output hsrb_pkg::entry_type      q_entry
);
   import hsrb_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;
   localparam bit WRAP = NODE_DEPTH < 1024;
   localparam logic [19:0] RECIP = 20'((1 << 20) / NODE_DEPTH);
   localparam logic [10:0] MODULUS = WRAP ? 11'(NODE_DEPTH) : 11'd1024;

   entry_type        queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push;
   entry_type        new_entry;

   // Remainder by the table depth: reciprocal estimate, then one correction.
   function automatic logic [IDX_W-1:0] wrap_index(input logic [IDX_W-1:0] v);
      logic [29:0] prod;
      logic [9:0]  q;
      logic [20:0] qd;
      logic [10:0] r;
      prod = 30'(v) * 30'(RECIP);
      q    = prod[29:20];
      qd   = 21'(q) * 21'(MODULUS);
      r    = {1'b0, v} - qd[10:0];
      if (r >= MODULUS) begin
         r = r - MODULUS;
      end
      return WRAP ? r[IDX_W-1:0] : v;
   endfunction

   function automatic link_type make_link(input logic [10:0] f);
      link_type l;
      l.absent = f[10];
      l.idx    = wrap_index(f[9:0]);
      return l;
   endfunction

   assign busy    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push    = start && !busy;
   assign q_valid = (count_ff != '0);
   assign q_entry = queue_ff[rd_ptr_ff];

   always_comb begin
      new_entry.build   = (req_type == REQ_BUILD);
      new_entry.row     = req_node_index;
      new_entry.slot    = wrap_index(req_node_index);
      new_entry.x       = req_pos_x;
      new_entry.y       = req_pos_y;
      new_entry.k       = req_conductivity;
      new_entry.link[0] = make_link(req_east_neighbor);
      new_entry.link[1] = make_link(req_north_neighbor);
      new_entry.link[2] = make_link(req_west_neighbor);
      new_entry.link[3] = make_link(req_south_neighbor);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== rtl/hsrb_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module hsrb_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] num,
   input  logic [32:0] den,
   output logic [47:0] quo,
   output logic        done
);
   import hsrb_pkg::*;

   localparam int STEPS = 48;

   logic        run_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [32:0] rem_ff;
   logic [47:0] num_ff;
   logic [32:0] den_ff;
   logic [47:0] quo_ff;
   logic [33:0] trial;
   logic [33:0] diff;
   logic        fits;

   assign trial = {rem_ff, num_ff[47]};
   assign fits  = (trial >= {1'b0, den_ff});
   assign diff  = trial - {1'b0, den_ff};
   assign quo   = quo_ff;
   assign done  = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= '0;
            num_ff <= num;
            den_ff <= den;
         end else if (run_ff) begin
            rem_ff <= fits ? diff[32:0] : trial[32:0];
            num_ff <= {num_ff[46:0], 1'b0};
            quo_ff <= {quo_ff[46:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 6'(STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// ===== rtl/hsrb_mul.sv =====
// Signed Q32.16 multiplier built from four 24x24 partial products, saturated to 48 bits.
module hsrb_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [47:0] a,
   input  logic signed [47:0] b,
   output logic signed [47:0] res,
   output logic               done
);
   import hsrb_pkg::*;

   localparam int HALF = 24;

   logic        run_ff;
   logic        done_ff;
   logic [2:0]  step_ff;
   logic        neg_ff;
   logic [47:0] ua_ff;
   logic [47:0] ub_ff;
   logic [47:0] pp_ff;
   logic [1:0]  ppsh_ff;
   logic        ppv_ff;
   logic [95:0] acc_ff;
   logic [HALF-1:0] opa;
   logic [HALF-1:0] opb;
   logic [1:0]  sh;
   logic [95:0] pp_shifted;
   logic [79:0] mag;

   assign opa = step_ff[1] ? ua_ff[47:HALF] : ua_ff[HALF-1:0];
   assign opb = step_ff[0] ? ub_ff[47:HALF] : ub_ff[HALF-1:0];

   always_comb begin
      case (step_ff)
         3'd0:    sh = 2'd0;
         3'd3:    sh = 2'd2;
         default: sh = 2'd1;
      endcase
      case (ppsh_ff)
         2'd0:    pp_shifted = 96'(pp_ff);
         2'd1:    pp_shifted = 96'(pp_ff) << HALF;
         default: pp_shifted = 96'(pp_ff) << (2 * HALF);
      endcase
   end

   // The product keeps 16 fraction bits after the shift; anything at or above 2^47 saturates.
   assign mag  = acc_ff[95:16];
   assign done = done_ff;

   always_comb begin
      if (|mag[79:47]) begin
         res = neg_ff ? COEF_MIN : COEF_MAX;
      end else begin
         res = neg_ff ? -mag[47:0] : mag[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         ppv_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
            ppv_ff  <= 1'b0;
            acc_ff  <= '0;
            neg_ff  <= a[47] != b[47];
            ua_ff   <= a[47] ? -a : a;
            ub_ff   <= b[47] ? -b : b;
         end else if (run_ff) begin
            if (step_ff != 3'd4) begin
               pp_ff   <= 48'(opa) * 48'(opb);
               ppsh_ff <= sh;
               ppv_ff  <= 1'b1;
               step_ff <= step_ff + 1'b1;
            end else begin
               ppv_ff <= 1'b0;
               if (!ppv_ff) begin
                  run_ff  <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
            if (ppv_ff) begin
               acc_ff <= acc_ff + pp_shifted;
            end
         end
      end
   end

endmodule

// ===== rtl/hsrb_back.sv =====
// Back end: node table, row sequencer, dividers and multiplier, and the result register.
module hsrb_back #(
   parameter int NODE_DEPTH = hsrb_pkg::DEF_NODE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  hsrb_pkg::entry_type q_entry,
   output logic                pop,
   input  logic [31:0]         time_step,
   input  logic [31:0]         hot_value,
   output logic                rsp_valid,
   output logic [9:0]          rsp_row_index,
   output logic [9:0]          rsp_col_index,
   output logic signed [47:0]  rsp_coefficient,
   output logic [1:0]          rsp_load_kind,
   output logic [31:0]         rsp_load_value,
   output logic                rsp_divide_fault,
   output logic                rsp_is_last
);
   import hsrb_pkg::*;

   localparam int AW = $clog2(NODE_DEPTH);
   localparam logic [2:0] MUL_LAST  = 3'd5;
   localparam logic [2:0] EMIT_LAST = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE, S_OWN, S_NB, S_SPAN, S_START, S_DIV, S_MUL, S_SUM, S_EMIT
   } state_type;

   function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] v);
      logic [AW+IDX_W-1:0] w;
      w = {{AW{1'b0}}, v};
      return w[AW-1:0];
   endfunction

   function automatic logic signed [47:0] div_post(input logic [47:0] q, input logic neg,
                                                   input logic zero);
      if (zero) begin
         return COEF_MAX;
      end
      if (!neg) begin
         return q[47] ? COEF_MAX : q;
      end
      if (q[47] && |q[46:0]) begin
         return COEF_MIN;
      end
      return -q;
   endfunction

   // Node table
   logic [31:0]    x_mem [NODE_DEPTH];
   logic [31:0]    y_mem [NODE_DEPTH];
   logic [31:0]    k_mem [NODE_DEPTH];
   link_type [3:0] nb_mem [NODE_DEPTH];
   logic [31:0]    x_q;
   logic [31:0]    y_q;
   logic [31:0]    k_q;
   link_type [3:0] nb_q;
   logic [AW-1:0]  rd_addr;
   logic           mem_we;

   state_type          state_ff;
   logic [IDX_W-1:0]   row_ff;
   logic signed [31:0] x_own_ff;
   logic signed [31:0] y_own_ff;
   logic [31:0]        k_own_ff;
   link_type [3:0]     link_ff;
   logic [1:0]         nb_cnt_ff;
   logic signed [31:0] xs_ff [4];
   logic signed [31:0] ys_ff [4];
   logic [31:0]        kd_ff [4];
   logic signed [32:0] pdx_ff;
   logic signed [32:0] ndx_ff;
   logic signed [32:0] pdy_ff;
   logic signed [32:0] ndy_ff;
   logic [5:0]         den_neg_ff;
   logic [5:0]         den_zero_ff;
   logic signed [47:0] qv_ff [6];
   logic [2:0]         mul_idx_ff;
   logic               mul_run_ff;
   logic signed [47:0] prod_ff [6];
   logic signed [47:0] diag_ff;
   logic               fault_ff;
   logic [2:0]         emit_cnt_ff;

   logic               rsp_valid_ff;
   logic [9:0]         rsp_row_ff;
   logic [9:0]         rsp_col_ff;
   logic signed [47:0] rsp_coef_ff;
   logic [1:0]         rsp_kind_ff;
   logic [31:0]        rsp_load_ff;
   logic               rsp_fault_ff;
   logic               rsp_last_ff;

   logic signed [33:0] sum_x;
   logic signed [33:0] sum_y;
   logic signed [33:0] half_x;
   logic signed [33:0] half_y;
   logic signed [32:0] den_c [6];
   logic [32:0]        den_mag [6];
   logic [47:0]        num_c [6];
   logic [47:0]        quo [6];
   logic [5:0]         div_done;
   logic               div_start;
   logic signed [47:0] sum_ns;
   logic signed [47:0] sum_ew;
   logic signed [47:0] mul_a;
   logic signed [47:0] mul_b;
   logic signed [47:0] mul_res;
   logic               mul_done;
   logic               mul_start;
   logic [1:0]         eidx;

   assign pop    = (state_ff == S_IDLE) && q_valid;
   assign mem_we = pop && !q_entry.build;

   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = to_addr(q_entry.slot);
         S_OWN:   rd_addr = to_addr(nb_q[0].idx);
         S_NB:    rd_addr = to_addr(link_ff[2'(nb_cnt_ff + 2'd1)].idx);
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         x_mem[to_addr(q_entry.slot)]  <= q_entry.x;
         y_mem[to_addr(q_entry.slot)]  <= q_entry.y;
         k_mem[to_addr(q_entry.slot)]  <= q_entry.k;
         nb_mem[to_addr(q_entry.slot)] <= q_entry.link;
      end
      x_q  <= x_mem[rd_addr];
      y_q  <= y_mem[rd_addr];
      k_q  <= k_mem[rd_addr];
      nb_q <= nb_mem[rd_addr];
   end

   // Mean spacings truncate toward zero, as the halving of a signed sum.
   always_comb begin
      sum_x  = 34'(pdx_ff) + 34'(ndx_ff);
      sum_y  = 34'(pdy_ff) + 34'(ndy_ff);
      half_x = (sum_x + 34'(sum_x[33])) >>> 1;
      half_y = (sum_y + 34'(sum_y[33])) >>> 1;
      den_c[0] = half_x[32:0];
      den_c[1] = half_y[32:0];
      den_c[2] = pdx_ff;
      den_c[3] = pdy_ff;
      den_c[4] = ndx_ff;
      den_c[5] = ndy_ff;
      num_c[0] = {time_step, 16'b0};
      num_c[1] = {time_step, 16'b0};
      num_c[2] = {kd_ff[0], 16'b0};
      num_c[3] = {kd_ff[1], 16'b0};
      num_c[4] = {kd_ff[2], 16'b0};
      num_c[5] = {kd_ff[3], 16'b0};
      for (int i = 0; i < 6; i++) begin
         den_mag[i] = den_c[i][32] ? -den_c[i] : den_c[i];
      end
   end

   assign div_start = (state_ff == S_START);

   for (genvar i = 0; i < 6; i++) begin : g_div
      hsrb_div u_div (
         .clock (clock),
         .reset (reset),
         .start (div_start),
         .num   (num_c[i]),
         .den   (den_mag[i]),
         .quo   (quo[i]),
         .done  (div_done[i])
      );
   end

   // Quotient order: qx, qy, east, north, west, south.
   assign sum_ns = sat48(ext49(qv_ff[3]) + ext49(qv_ff[5]));
   assign sum_ew = sat48(ext49(qv_ff[2]) + ext49(qv_ff[4]));

   always_comb begin
      case (mul_idx_ff)
         3'd0:    begin mul_a = qv_ff[0]; mul_b = qv_ff[2]; end
         3'd1:    begin mul_a = qv_ff[1]; mul_b = qv_ff[3]; end
         3'd2:    begin mul_a = qv_ff[0]; mul_b = qv_ff[4]; end
         3'd3:    begin mul_a = qv_ff[1]; mul_b = qv_ff[5]; end
         3'd4:    begin mul_a = qv_ff[1]; mul_b = sum_ns; end
         default: begin mul_a = qv_ff[0]; mul_b = sum_ew; end
      endcase
   end

   assign mul_start = (state_ff == S_MUL) && !mul_run_ff;

   hsrb_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .res   (mul_res),
      .done  (mul_done)
   );

   assign eidx = 2'(emit_cnt_ff - 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_run_ff   <= 1'b0;
         nb_cnt_ff    <= '0;
         mul_idx_ff   <= '0;
         emit_cnt_ff  <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  row_ff <= q_entry.row;
                  if (q_entry.build) begin
                     state_ff <= S_OWN;
                  end
               end
            end
            S_OWN: begin
               x_own_ff <= x_q;
               y_own_ff <= y_q;
               k_own_ff <= k_q;
               link_ff  <= nb_q;
               if (nb_q[3].absent || nb_q[0].absent || nb_q[1].absent || nb_q[2].absent) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_row_ff   <= row_ff;
                  rsp_col_ff   <= row_ff;
                  rsp_coef_ff  <= COEF_ONE;
                  rsp_kind_ff  <= nb_q[3].absent ? LOAD_HOT : LOAD_ZERO;
                  rsp_load_ff  <= nb_q[3].absent ? hot_value : '0;
                  rsp_fault_ff <= 1'b0;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  nb_cnt_ff <= '0;
                  state_ff  <= S_NB;
               end
            end
            S_NB: begin
               xs_ff[nb_cnt_ff] <= x_q;
               ys_ff[nb_cnt_ff] <= y_q;
               kd_ff[nb_cnt_ff] <= 32'((33'(k_own_ff) + 33'(k_q)) >> 1);
               nb_cnt_ff <= nb_cnt_ff + 1'b1;
               if (nb_cnt_ff == 2'd3) begin
                  state_ff <= S_SPAN;
               end
            end
            S_SPAN: begin
               pdx_ff   <= 33'(xs_ff[0]) - 33'(x_own_ff);
               ndx_ff   <= 33'(x_own_ff) - 33'(xs_ff[2]);
               pdy_ff   <= 33'(ys_ff[1]) - 33'(y_own_ff);
               ndy_ff   <= 33'(y_own_ff) - 33'(ys_ff[3]);
               state_ff <= S_START;
            end
            S_START: begin
               for (int i = 0; i < 6; i++) begin
                  den_neg_ff[i]  <= den_c[i][32];
                  den_zero_ff[i] <= (den_c[i] == '0);
               end
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (&div_done) begin
                  for (int i = 0; i < 6; i++) begin
                     qv_ff[i] <= div_post(quo[i], den_neg_ff[i], den_zero_ff[i]);
                  end
                  fault_ff   <= |den_zero_ff;
                  mul_idx_ff <= '0;
                  mul_run_ff <= 1'b0;
                  state_ff   <= S_MUL;
               end
            end
            S_MUL: begin
               if (!mul_run_ff) begin
                  mul_run_ff <= 1'b1;
               end else if (mul_done) begin
                  prod_ff[mul_idx_ff] <= mul_res;
                  mul_run_ff <= 1'b0;
                  mul_idx_ff <= mul_idx_ff + 1'b1;
                  if (mul_idx_ff == MUL_LAST) begin
                     state_ff <= S_SUM;
                  end
               end
            end
            S_SUM: begin
               diag_ff     <= sat48(ext49(COEF_ONE)
                                    + ext49(sat48(ext49(prod_ff[4]) + ext49(prod_ff[5]))));
               emit_cnt_ff <= '0;
               state_ff    <= S_EMIT;
            end
            S_EMIT: begin
               rsp_valid_ff <= 1'b1;
               rsp_row_ff   <= row_ff;
               rsp_kind_ff  <= LOAD_PREV;
               rsp_load_ff  <= '0;
               rsp_fault_ff <= fault_ff;
               rsp_last_ff  <= (emit_cnt_ff == EMIT_LAST);
               if (emit_cnt_ff == '0) begin
                  rsp_col_ff  <= row_ff;
                  rsp_coef_ff <= diag_ff;
               end else begin
                  rsp_col_ff  <= link_ff[eidx].idx;
                  rsp_coef_ff <= sat48(-ext49(prod_ff[{1'b0, eidx}]));
               end
               emit_cnt_ff <= emit_cnt_ff + 1'b1;
               if (emit_cnt_ff == EMIT_LAST) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row_index    = rsp_row_ff;
   assign rsp_col_index    = rsp_col_ff;
   assign rsp_coefficient  = rsp_coef_ff;
   assign rsp_load_kind    = rsp_kind_ff;
   assign rsp_load_value   = rsp_load_ff;
   assign rsp_divide_fault = rsp_fault_ff;
   assign rsp_is_last      = rsp_last_ff;

endmodule

// ===== rtl/heat_stencil_row_builder_unit.sv =====
// Top level of the heat stencil row builder: configuration registers, front end and back end.
//
// Items enter on the req_ ports when start is high and busy is low. A load item
// (req_type 0) writes one node of the table and yields no result. A build item
// (req_type 1) yields the matrix row of that node on the rsp_ ports, one entry per
// cycle, each marked by rsp_valid for a single cycle; rsp_is_last flags the final one.
// The receiver cannot stall, so entries are never held back once produced.
// A four-item queue sits between the front end and the back end, so new items are
// taken while a row is still being worked out; busy rises only when it is full.
// Loads are written to the table as they leave the queue. A boundary row gives its
// single entry once the table read of its own node is registered. An interior row
// passes through the table reads of its node and four neighbors, two setup states, six
// parallel 48-step serial dividers, a shared multiplier forming six products in turn,
// a summing state, then five entries, one per cycle. Configuration is written through
// csr_we, csr_index and csr_wdata only while idle; the user must ensure this, the block does not.
// Reset clears the queue and sequencer and restores the register defaults
// (time step 655, hot value 100.0); the node table holds no defined contents.
module heat_stencil_row_builder_unit #(
   parameter int NODE_DEPTH = hsrb_pkg::DEF_NODE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_type,
   input  logic [9:0]                     req_node_index,
   input  logic signed [31:0]             req_pos_x,
   input  logic signed [31:0]             req_pos_y,
   input  logic [31:0]                    req_conductivity,
   input  logic signed [10:0]             req_east_neighbor,
   input  logic signed [10:0]             req_north_neighbor,
   input  logic signed [10:0]             req_west_neighbor,
   input  logic signed [10:0]             req_south_neighbor,
   output logic                           rsp_valid,
   output logic [9:0]                     rsp_row_index,
   output logic [9:0]                     rsp_col_index,
   output logic signed [47:0]             rsp_coefficient,
   output logic [1:0]                     rsp_load_kind,
   output logic [31:0]                    rsp_load_value,
   output logic                           rsp_divide_fault,
   output logic                           rsp_is_last,
   input  logic                           csr_we,
   input  logic [hsrb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);
   import hsrb_pkg::*;

   logic [31:0] time_step_ff;
   logic [31:0] hot_value_ff;
   logic        q_valid;
   logic        pop;
   entry_type   q_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
         hot_value_ff <= HOT_VALUE_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_TIME_STEP) begin
            time_step_ff <= csr_wdata;
         end
         if (csr_index == CSR_HOT_VALUE) begin
            hot_value_ff <= csr_wdata;
         end
      end
   end

   hsrb_front #(
      .NODE_DEPTH (NODE_DEPTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_node_index     (req_node_index),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_conductivity   (req_conductivity),
      .req_east_neighbor  (req_east_neighbor),
      .req_north_neighbor (req_north_neighbor),
      .req_west_neighbor  (req_west_neighbor),
      .req_south_neighbor (req_south_neighbor),
      .pop                (pop),
      .q_valid            (q_valid),
      .q_entry            (q_entry)
   );

   hsrb_back #(
      .NODE_DEPTH (NODE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .pop              (pop),
      .time_step        (time_step_ff),
      .hot_value        (hot_value_ff),
      .rsp_valid        (rsp_valid),
      .rsp_row_index    (rsp_row_index),
      .rsp_col_index    (rsp_col_index),
      .rsp_coefficient  (rsp_coefficient),
      .rsp_load_kind    (rsp_load_kind),
      .rsp_load_value   (rsp_load_value),
      .rsp_divide_fault (rsp_divide_fault),
      .rsp_is_last      (rsp_is_last)
   );

endmodule

// ===== tb/tb_heat_stencil_row_builder_unit.sv =====
// Self-checking testbench of the heat stencil row builder: directed table, then random items.
`timescale 1ns / 100ps

module tb_heat_stencil_row_builder_unit;
   import hsrb_pkg::*;

   localparam longint C_MAX = 64'sd140737488355327;
   localparam longint C_MIN = -64'sd140737488355328;
   localparam int     DRAIN_CYCLES = 300;

   typedef struct {
      logic [9:0]  row;
      logic [9:0]  col;
      logic [47:0] coef;
      logic [1:0]  kind;
      logic [31:0] load;
      logic        fault;
      logic        last;
   } result_type;

   typedef struct {
      logic        kind;
      logic [9:0]  idx;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] k;
      logic [10:0] e;
      logic [10:0] n;
      logic [10:0] w;
      logic [10:0] s;
      bit          typed;
      logic [1:0]  exp_kind;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_type = REQ_LOAD;
   logic [9:0]  req_node_index = '0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic [31:0] req_conductivity = '0;
   logic signed [10:0] req_east_neighbor = '0;
   logic signed [10:0] req_north_neighbor = '0;
   logic signed [10:0] req_west_neighbor = '0;
   logic signed [10:0] req_south_neighbor = '0;
   logic        rsp_valid;
   logic [9:0]  rsp_row_index;
   logic [9:0]  rsp_col_index;
   logic signed [47:0] rsp_coefficient;
   logic [1:0]  rsp_load_kind;
   logic [31:0] rsp_load_value;
   logic        rsp_divide_fault;
   logic        rsp_is_last;
   logic        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TIME_STEP;
   logic [31:0] csr_wdata = '0;

   heat_stencil_row_builder_unit u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the node table and the registers.
   logic [31:0] node_x_tab [1024];
   logic [31:0] node_y_tab [1024];
   logic [31:0] node_k_tab [1024];
   logic [10:0] node_link_tab [1024][4];
   bit          node_loaded [1024];
   logic [31:0] dt_reg;
   logic [31:0] hot_reg;
   bit          row_fault;

   result_type pending_entries [$];
   int     error_count = 0;
   int     entries_checked = 0;
   int     loads_sent = 0;
   int     builds_sent = 0;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   function automatic longint sat48(input longint v);
      if (v > C_MAX) return C_MAX;
      if (v < C_MIN) return C_MIN;
      return v;
   endfunction

   function automatic longint quotient(input longint num, input longint den);
      if (den == 0) begin
         row_fault = 1'b1;
         return num < 0 ? -C_MAX : C_MAX;
      end
      return sat48((num * 65536) / den);
   endfunction

   function automatic longint fix_product(input longint a, input longint b);
      bit           neg;
      logic [127:0] ua;
      logic [127:0] ub;
      logic [127:0] mag;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? 128'(-a) : 128'(a);
      ub = b < 0 ? 128'(-b) : 128'(b);
      mag = (ua * ub) >> 16;
      if (mag > 128'(C_MAX)) return neg ? C_MIN : C_MAX;
      return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
   endfunction

   function automatic void push_entry(input logic [9:0] row, input logic [9:0] col,
                                      input longint coef, input logic [1:0] kind,
                                      input logic [31:0] load, input bit flt,
                                      input bit last);
      result_type ent;
      longint c;
      c = sat48(coef);
      ent.row = row; ent.col = col; ent.coef = c[47:0]; ent.kind = kind;
      ent.load = load; ent.fault = flt; ent.last = last;
      pending_entries.push_back(ent);
   endfunction

   // Works out the matrix row of one node from the shadow table.
   function automatic void assemble_row(input logic [9:0] row);
      logic [9:0]  nb [4];
      bit          gone [4];
      longint      kf [4];
      longint      xs [4];
      longint      ys [4];
      longint      x, y, pdx, ndx, pdy, ndy, dx, dy, qx, qy, te, tn, tw, ts, sum;
      for (int d = 0; d < 4; d++) begin
         gone[d] = node_link_tab[row][d][10];
         nb[d] = node_link_tab[row][d][9:0];
      end
      if (gone[3]) begin
         push_entry(row, row, 65536, LOAD_HOT, hot_reg, 0, 1);
         return;
      end
      if (gone[0] || gone[1] || gone[2]) begin
         push_entry(row, row, 65536, LOAD_ZERO, 0, 0, 1);
         return;
      end
      x = longint'($signed(node_x_tab[row]));
      y = longint'($signed(node_y_tab[row]));
      for (int d = 0; d < 4; d++) begin
         kf[d] = longint'(({1'b0, node_k_tab[row]} + {1'b0, node_k_tab[nb[d]]}) >> 1);
         xs[d] = longint'($signed(node_x_tab[nb[d]]));
         ys[d] = longint'($signed(node_y_tab[nb[d]]));
      end
      pdx = xs[0] - x;
      ndx = x - xs[2];
      dx = (pdx + ndx) / 2;
      pdy = ys[1] - y;
      ndy = y - ys[3];
      dy = (pdy + ndy) / 2;
      row_fault = 1'b0;
      qx = quotient(longint'(dt_reg), dx);
      qy = quotient(longint'(dt_reg), dy);
      te = quotient(kf[0], pdx);
      tn = quotient(kf[1], pdy);
      tw = quotient(kf[2], ndx);
      ts = quotient(kf[3], ndy);
      sum = sat48(fix_product(qy, sat48(tn + ts)) + fix_product(qx, sat48(te + tw)));
      push_entry(row, row, 65536 + sum, LOAD_PREV, 0, row_fault, 0);
      push_entry(row, nb[0], -fix_product(qx, te), LOAD_PREV, 0, row_fault, 0);
      push_entry(row, nb[1], -fix_product(qy, tn), LOAD_PREV, 0, row_fault, 0);
      push_entry(row, nb[2], -fix_product(qx, tw), LOAD_PREV, 0, row_fault, 0);
      push_entry(row, nb[3], -fix_product(qy, ts), LOAD_PREV, 0, row_fault, 1);
   endfunction

   // A build is only issued where every table entry it reads has been written.
   function automatic bit row_ready(input logic [9:0] row);
      if (!node_loaded[row]) return 0;
      if (node_link_tab[row][3][10]) return 1;
      if (node_link_tab[row][0][10] || node_link_tab[row][1][10] ||
          node_link_tab[row][2][10]) return 1;
      for (int d = 0; d < 4; d++) begin
         if (!node_loaded[node_link_tab[row][d][9:0]]) return 0;
      end
      return 1;
   endfunction

   // Drives one item, holds it until accepted and updates the shadow state.
   task automatic send_item(input stim_type it, input int gap);
      req_type <= it.kind;
      req_node_index <= it.idx;
      req_pos_x <= it.x;
      req_pos_y <= it.y;
      req_conductivity <= it.k;
      req_east_neighbor <= it.e;
      req_north_neighbor <= it.n;
      req_west_neighbor <= it.w;
      req_south_neighbor <= it.s;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (it.kind == REQ_LOAD) begin
         node_x_tab[it.idx] = it.x;
         node_y_tab[it.idx] = it.y;
         node_k_tab[it.idx] = it.k;
         node_link_tab[it.idx][0] = it.e;
         node_link_tab[it.idx][1] = it.n;
         node_link_tab[it.idx][2] = it.w;
         node_link_tab[it.idx][3] = it.s;
         node_loaded[it.idx] = 1;
         loads_sent++;
      end else begin
         builds_sent++;
         if (it.typed)
            push_entry(it.idx, it.idx, 65536, it.exp_kind,
                       it.exp_kind == LOAD_HOT ? hot_reg : 32'd0, 0, 1);
         else
            assemble_row(it.idx);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic stop_sending();
      start <= 1'b0;
      @(posedge clock);
   endtask

   // Waits for every expected entry, then lets any load still queued retire.
   task automatic drain();
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TIME_STEP) dt_reg = val;
      else hot_reg = val;
      @(posedge clock);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(20, 120);
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid) begin
         if (pending_entries.size() == 0) begin
            report_mismatch("entry with no expectation waiting");
         end else begin
            want = pending_entries.pop_front();
            entries_checked++;
            if (rsp_row_index !== want.row)
               report_mismatch($sformatf("row %0d, want %0d", rsp_row_index, want.row));
            if (rsp_col_index !== want.col)
               report_mismatch($sformatf("row %0d col %0d, want %0d",
                                         want.row, rsp_col_index, want.col));
            if (rsp_coefficient !== want.coef)
               report_mismatch($sformatf("row %0d col %0d coefficient %h, want %h",
                                         want.row, want.col, rsp_coefficient, want.coef));
            if (rsp_load_kind !== want.kind)
               report_mismatch($sformatf("row %0d load kind %0d, want %0d",
                                         want.row, rsp_load_kind, want.kind));
            if (rsp_load_value !== want.load)
               report_mismatch($sformatf("row %0d load value %h, want %h",
                                         want.row, rsp_load_value, want.load));
            if (rsp_divide_fault !== want.fault)
               report_mismatch($sformatf("row %0d divide fault %b, want %b",
                                         want.row, rsp_divide_fault, want.fault));
            if (rsp_is_last !== want.last)
               report_mismatch($sformatf("row %0d last flag %b, want %b",
                                         want.row, rsp_is_last, want.last));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d entries outstanding", pending_entries.size());
      $display("heat_stencil_row_builder_unit regression: fail");
      $finish;
   end

   localparam logic [10:0] NONE = 11'h7FF;
   localparam logic [31:0] ONE = 32'h0001_0000;

   stim_type directed [] = '{
      // A plus-shaped patch: center 0 with four boundary neighbors.
      '{REQ_LOAD, 10'd0, 32'h0, 32'h0, ONE, 11'd1, 11'd2, 11'd3, 11'd4, 0, LOAD_HOT},
      '{REQ_LOAD, 10'd1, ONE, 32'h0, ONE, NONE, NONE, 11'd0, NONE, 0, LOAD_HOT},
      '{REQ_LOAD, 10'd2, 32'h0, ONE, 32'h2_0000, 11'd0, NONE, NONE, 11'd0, 0, LOAD_HOT},
      '{REQ_LOAD, 10'd3, -ONE, 32'h0, ONE, 11'd0, 11'd0, 11'h500, 11'd0, 0, LOAD_HOT},
      '{REQ_LOAD, 10'd4, 32'h0, -ONE, 32'h0, 11'd0, 11'd0, 11'd0, 11'h400, 0, LOAD_HOT},
      '{REQ_BUILD, 10'd1, 32'h0, 32'h0, 32'h0, 11'd0, 11'd0, 11'd0, 11'd0, 1, LOAD_HOT},
      '{REQ_BUILD, 10'd2, 32'h0, 32'h0, 32'h0, 11'd0, 11'd0, 11'd0, 11'd0, 1, LOAD_ZERO},
      '{REQ_BUILD, 10'd3, 32'h0, 32'h0, 32'h0, 11'd0, 11'd0, 11'd0, 11'd0, 1, LOAD_ZERO},
      '{REQ_BUILD, 10'd4, 32'h0, 32'h0, 32'h0, 11'd0, 11'd0, 11'd0, 11'd0, 1, LOAD_HOT},
      '{REQ_BUILD, 10'd0, 32'h0, 32'h0, 32'h0, 11'd0, 11'd0, 11'd0, 11'd0, 0, LOAD_HOT},
      // Zero spacing: every neighbor shares the node's position.
      '{REQ_LOAD, 10'd5, 32'h0, 32'h0, 32'hFFFF_FFFF, 11'd0, 11'd0, 11'd0, 11'd0, 0, LOAD_HOT},
      '{REQ_BUILD, 10'd5, 32'h0, 32'h0, 32'h0, 11'd0, 11'd0, 11'd0, 11'd0, 0, LOAD_HOT},
      // Extreme coordinates and conductivity at the top and middle of the table.
      '{REQ_LOAD, 10'd1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
        11'd1, 11'd2, 11'd3, 11'd4, 0, LOAD_HOT},
      '{REQ_BUILD, 10'd1023, 32'h0, 32'h0, 32'h0, 11'd0, 11'd0, 11'd0, 11'd0, 0, LOAD_HOT},
      '{REQ_LOAD, 10'd512, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
        11'd1023, 11'd1023, 11'd1023, 11'd1023, 0, LOAD_HOT},
      '{REQ_BUILD, 10'd512, 32'h0, 32'h0, 32'h0, 11'd0, 11'd0, 11'd0, 11'd0, 0, LOAD_HOT},
      '{REQ_LOAD, 10'd6, 32'h3, 32'h5, 32'h1, 11'd1023, 11'd512, 11'd0, 11'd5, 0, LOAD_HOT},
      '{REQ_BUILD, 10'd6, 32'h0, 32'h0, 32'h0, 11'd0, 11'd0, 11'd0, 11'd0, 0, LOAD_HOT}
   };

   logic [9:0] index_pool [24];

   function automatic logic [10:0] random_link();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return {1'b0, index_pool[$urandom_range(0, 23)]};
      if (r < 92) return NONE;
      return {1'b1, 10'($urandom)};
   endfunction

   function automatic logic [31:0] random_coord();
      if ($urandom_range(0, 9) < 8) return 32'($urandom_range(0, 16)) << 14;
      return $urandom;
   endfunction

   initial begin
      stim_type it;
      logic [9:0] cand;
      int picked;
      logic [31:0] dt_set [4];
      logic [31:0] hot_set [4];

      dt_reg = TIME_STEP_RESET;
      hot_reg = HOT_VALUE_RESET;
      index_pool[0] = 10'd0;
      index_pool[1] = 10'd1023;
      index_pool[2] = 10'h155;
      index_pool[3] = 10'h2AA;
      for (int i = 4; i < 24; i++) index_pool[i] = 10'($urandom);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_item(directed[i], i % 3 == 0 ? 2 : 0);
      stop_sending();
      drain();

      dt_set[0] = 32'd1;          hot_set[0] = 32'h0;
      dt_set[1] = 32'hFFFF_FFFF;  hot_set[1] = 32'hFFFF_FFFF;
      dt_set[2] = $urandom;       hot_set[2] = $urandom;
      dt_set[3] = 32'h0000_4000;  hot_set[3] = HOT_VALUE_RESET;

      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_TIME_STEP, dt_set[ph]);
         write_reg(CSR_HOT_VALUE, hot_set[ph]);
         for (int n = 0; n < 42; n++) begin
            it = '{default: '0};
            picked = 0;
            if ($urandom_range(0, 99) < 55) begin
               for (int t = 0; t < 8 && !picked; t++) begin
                  cand = index_pool[$urandom_range(0, 23)];
                  if (row_ready(cand)) picked = 1;
               end
            end
            if (picked) begin
               it.kind = REQ_BUILD;
               it.idx = cand;
               it.x = $urandom;
               it.y = $urandom;
               it.k = $urandom;
               it.e = 11'($urandom);
               it.n = 11'($urandom);
               it.w = 11'($urandom);
               it.s = 11'($urandom);
            end else begin
               it.kind = REQ_LOAD;
               it.idx = index_pool[$urandom_range(0, 23)];
               it.x = random_coord();
               it.y = random_coord();
               it.k = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 32'h8_0000));
               it.e = random_link();
               it.n = random_link();
               it.w = random_link();
               it.s = random_link();
            end
            send_item(it, pick_gap());
         end
         stop_sending();
         drain();
      end

      $display("Sent %0d loads and %0d builds over four register settings,",
               loads_sent, builds_sent);
      $display("checked %0d matrix entries including boundary and zero-spacing rows.",
               entries_checked);
      if (error_count == 0 && pending_entries.size() == 0) begin
         $display("heat_stencil_row_builder_unit regression: pass");
      end else begin
         $display("heat_stencil_row_builder_unit regression: fail");
      end
      $finish;
   end

endmodule
